// ----- sv/csd_pkg.sv -----
// Shared widths and codes of the convergence stall detector.
// Depends on nothing; imported by the ring store and the top level.
`timescale 1ns / 1ps

package csd_pkg;

  localparam int ENT_W  = 24;
  localparam int CNT_W  = 24;
  localparam int ITER_W = 32;
  localparam int WIN_W  = 5;
  localparam int THR_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING    = 2'd2;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam logic [1:0] STALL_NONE        = 2'd0;
  localparam logic [1:0] STALL_OSCILLATING = 2'd1;
  localparam logic [1:0] STALL_NO_PROGRESS = 2'd2;
  localparam logic [1:0] STALL_UNCERTAIN   = 2'd3;

  localparam logic [WIN_W-1:0] WINDOW_RESET   = 5'd5;
  localparam logic [THR_W-1:0] PROGRESS_RESET = 24'd655;
  localparam logic [THR_W-1:0] SWING_RESET    = 24'd6554;

endpackage

// ----- sv/csd_ring.sv -----
// History store: entropy and uncertain-count rings, one write port and
// one registered read port each. Depends on csd_pkg.
`timescale 1ns / 1ps

module csd_ring #(
  parameter int DEPTH = 32,
  parameter int PW    = 5
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [PW-1:0]             wr_addr,
  input  logic [csd_pkg::ENT_W-1:0] wr_ent,
  input  logic [csd_pkg::CNT_W-1:0] wr_unc,
  input  logic                      ent_rd_en,
  input  logic [PW-1:0]             ent_rd_addr,
  output logic [csd_pkg::ENT_W-1:0] ent_rd_data,
  input  logic                      unc_rd_en,
  input  logic [PW-1:0]             unc_rd_addr,
  output logic [csd_pkg::CNT_W-1:0] unc_rd_data
);
  import csd_pkg::*;

  logic [ENT_W-1:0] ent_mem [DEPTH];
  logic [CNT_W-1:0] unc_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[wr_addr] <= wr_ent;
      unc_mem[wr_addr] <= wr_unc;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_rd_en) begin
      ent_rd_data <= ent_mem[ent_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (unc_rd_en) begin
      unc_rd_data <= unc_mem[unc_rd_addr];
    end
  end

endmodule

// ----- sv/convergence_stall_detector.sv -----
// Convergence stall detector top level: control, window walk and classification.
// Depends on csd_pkg and csd_ring.
// A clear, or a record while the history is shorter than one window, raises its result
// without a walk. Any other record first sets up and walks the effective window over the
// entropy ring at one read a cycle, then evaluates the window and raises its result.
// The next request is taken in the cycle the result is raised, later while a stalled
// result still holds the output register. Synchronous active-low reset empties the history.
`timescale 1ns / 1ps

module convergence_stall_detector #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [csd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [csd_pkg::ITER_W-1:0]     in_iteration_number,
  input  logic [csd_pkg::ENT_W-1:0]      in_entropy_value,
  input  logic [csd_pkg::CNT_W-1:0]      in_uncertain_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_stall_kind,
  output logic [csd_pkg::ITER_W-1:0]     out_stall_iteration,
  output logic [csd_pkg::ENT_W-1:0]      out_largest_swing,
  output logic [csd_pkg::ENT_W-1:0]      out_window_change,
  output logic [csd_pkg::CNT_W-1:0]      out_reads_involved
);
  import csd_pkg::*;

  localparam int DEPTH = 2 * MAX_WINDOW;
  localparam int PW    = $clog2(DEPTH);
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int CW    = ((FW > WIN_W) ? FW : WIN_W) + 1;
  localparam int IW    = $clog2(MAX_WINDOW);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_WALK  = 6'b000100,
    ST_LAST  = 6'b001000,
    ST_EVAL  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [WIN_W-1:0] win_r;
  logic [THR_W-1:0] prog_thr_r, swing_thr_r;

  logic [PW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic [PW-1:0] base_r, base_nxt;
  logic [PW-1:0] addr_r, addr_nxt;
  logic [IW-1:0] iss_r, iss_nxt;
  logic          rd_valid_r, rd_valid_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;

  logic [ITER_W-1:0] iter_r;
  logic [CNT_W-1:0]  newest_r;

  logic [ENT_W-1:0] first_r, prev_r;
  logic             p_pos_r, p_neg_r;
  logic [1:0]       chg_r;
  logic [ENT_W-1:0] max_r;

  logic [1:0]        res_kind_r, res_kind_nxt;
  logic [ITER_W-1:0] res_iter_r, res_iter_nxt;
  logic [ENT_W-1:0]  res_swing_r, res_swing_nxt;
  logic [ENT_W-1:0]  res_change_r, res_change_nxt;
  logic [CNT_W-1:0]  res_reads_r, res_reads_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r;
  logic [ITER_W-1:0] out_iter_r;
  logic [ENT_W-1:0]  out_swing_r, out_change_r;
  logic [CNT_W-1:0]  out_reads_r;

  logic             accept;
  logic             wr_en;
  logic             ent_rd_en, unc_rd_en;
  logic [ENT_W-1:0] ent_q;
  logic [CNT_W-1:0] unc_q;

  logic [CW-1:0] win_ext, eff_w, fill_ext, fill_inc, fill_cl;
  logic [CW-1:0] base_tmp, base_wr, start_tmp, start_wr;
  logic [CW-1:0] head_ext;

  logic signed [ENT_W:0] diff;
  logic                  d_pos, d_neg, reversal;
  logic [ENT_W-1:0]      diff_abs;

  logic [ENT_W-1:0]   delta;
  logic [CNT_W-1:0]   oldest;
  logic [CNT_W+2:0]   newest_x5, oldest_x4;
  logic               is_osc, is_nop, is_unc;
  logic               emit_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WINDOW_RESET;
      prog_thr_r  <= PROGRESS_RESET;
      swing_thr_r <= SWING_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW:   win_r       <= cfg_data[WIN_W-1:0];
        CFG_PROGRESS: prog_thr_r  <= cfg_data[THR_W-1:0];
        CFG_SWING:    swing_thr_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (in_kind == KIND_RECORD);

  always_comb begin
    win_ext = {{(CW-WIN_W){1'b0}}, win_r};
    if (win_ext == '0) begin
      eff_w = CW'(1);
    end else if (win_ext > CW'(MAX_WINDOW)) begin
      eff_w = CW'(MAX_WINDOW);
    end else begin
      eff_w = win_ext;
    end
    fill_ext = {{(CW-FW){1'b0}}, fill_r};
    fill_inc = fill_ext + CW'(1);
    fill_cl  = (fill_inc > (eff_w << 1)) ? fill_ext : fill_inc;
    if (fill_cl > CW'(DEPTH)) begin
      fill_cl = CW'(DEPTH);
    end
    head_ext  = {{(CW-PW){1'b0}}, head_r};
    base_tmp  = head_ext + CW'(DEPTH) - fill_ext;
    base_wr   = (base_tmp >= CW'(DEPTH)) ? base_tmp - CW'(DEPTH) : base_tmp;
    start_tmp = base_wr + fill_ext - w_r;
    start_wr  = (start_tmp >= CW'(DEPTH)) ? start_tmp - CW'(DEPTH) : start_tmp;
  end

  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    w_nxt          = w_r;
    base_nxt       = base_r;
    addr_nxt       = addr_r;
    iss_nxt        = iss_r;
    rd_valid_nxt   = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    res_kind_nxt   = res_kind_r;
    res_iter_nxt   = res_iter_r;
    res_swing_nxt  = res_swing_r;
    res_change_nxt = res_change_r;
    res_reads_nxt  = res_reads_r;
    ent_rd_en      = 1'b0;
    unc_rd_en      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_kind_nxt   = STALL_NONE;
          res_iter_nxt   = '0;
          res_swing_nxt  = '0;
          res_change_nxt = '0;
          res_reads_nxt  = '0;
          w_nxt          = eff_w;
          if (in_kind == KIND_CLEAR) begin
            head_nxt  = '0;
            fill_nxt  = '0;
            state_nxt = ST_EMIT;
          end else begin
            head_nxt  = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + PW'(1);
            fill_nxt  = fill_cl[FW-1:0];
            state_nxt = (fill_cl < eff_w) ? ST_EMIT : ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        base_nxt  = base_wr[PW-1:0];
        addr_nxt  = start_wr[PW-1:0];
        iss_nxt   = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        ent_rd_en    = 1'b1;
        unc_rd_en    = 1'b1;
        rd_valid_nxt = 1'b1;
        rd_idx_nxt   = iss_r;
        iss_nxt      = iss_r + IW'(1);
        addr_nxt     = (addr_r == PW'(DEPTH - 1)) ? '0 : addr_r + PW'(1);
        if ({{(CW-IW){1'b0}}, iss_r} == w_r - CW'(1)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (is_osc) begin
          res_kind_nxt   = STALL_OSCILLATING;
          res_iter_nxt   = iter_r;
          res_swing_nxt  = max_r;
          res_change_nxt = delta;
          res_reads_nxt  = newest_r;
        end else if (is_nop) begin
          res_kind_nxt   = STALL_NO_PROGRESS;
          res_iter_nxt   = iter_r;
          res_change_nxt = delta;
          res_reads_nxt  = newest_r;
        end else if (is_unc) begin
          res_kind_nxt   = STALL_UNCERTAIN;
          res_iter_nxt   = iter_r;
          res_reads_nxt  = newest_r;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      head_r     <= '0;
      fill_r     <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      fill_r     <= fill_nxt;
      rd_valid_r <= rd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    base_r       <= base_nxt;
    addr_r       <= addr_nxt;
    iss_r        <= iss_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_kind_r   <= res_kind_nxt;
    res_iter_r   <= res_iter_nxt;
    res_swing_r  <= res_swing_nxt;
    res_change_r <= res_change_nxt;
    res_reads_r  <= res_reads_nxt;
    if (accept) begin
      iter_r   <= in_iteration_number;
      newest_r <= in_uncertain_count;
    end
  end

  csd_ring #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_ring (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (head_r),
    .wr_ent      (in_entropy_value),
    .wr_unc      (in_uncertain_count),
    .ent_rd_en   (ent_rd_en),
    .ent_rd_addr (addr_r),
    .ent_rd_data (ent_q),
    .unc_rd_en   (unc_rd_en),
    .unc_rd_addr (base_r),
    .unc_rd_data (unc_q)
  );

  always_comb begin
    diff     = $signed({1'b0, ent_q}) - $signed({1'b0, prev_r});
    d_neg    = diff[ENT_W];
    d_pos    = !diff[ENT_W] && (diff != '0);
    reversal = (d_pos && p_neg_r) || (d_neg && p_pos_r);
    diff_abs = d_neg ? ENT_W'(-diff) : diff[ENT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SETUP) begin
      chg_r   <= '0;
      max_r   <= '0;
      p_pos_r <= 1'b0;
      p_neg_r <= 1'b0;
    end else if (rd_valid_r) begin
      prev_r <= ent_q;
      if (rd_idx_r == '0) begin
        first_r <= ent_q;
      end else begin
        p_pos_r <= d_pos;
        p_neg_r <= d_neg;
        if ((rd_idx_r >= IW'(2)) && reversal) begin
          if (chg_r != 2'd2) begin
            chg_r <= chg_r + 2'd1;
          end
          if (diff_abs > max_r) begin
            max_r <= diff_abs;
          end
        end
      end
    end
  end

  always_comb begin
    delta     = (prev_r >= first_r) ? prev_r - first_r : first_r - prev_r;
    oldest    = (unc_q == '0) ? CNT_W'(1) : unc_q;
    newest_x5 = ({3'b000, newest_r} << 2) + {3'b000, newest_r};
    oldest_x4 = {3'b000, oldest} << 2;
    is_osc    = (chg_r == 2'd2) && (max_r > swing_thr_r);
    is_nop    = (delta < prog_thr_r);
    is_unc    = (newest_r != '0) && (newest_x5 > oldest_x4);
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_kind_r   <= res_kind_r;
      out_iter_r   <= res_iter_r;
      out_swing_r  <= res_swing_r;
      out_change_r <= res_change_r;
      out_reads_r  <= res_reads_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_stall_kind      = out_kind_r;
  assign out_stall_iteration = out_iter_r;
  assign out_largest_swing   = out_swing_r;
  assign out_window_change   = out_change_r;
  assign out_reads_involved  = out_reads_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("A second request was taken straight after the first.");

  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("History fill level exceeds the ring depth.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_stall_kind == STALL_OSCILLATING)) |->
      (out_largest_swing > swing_thr_r))
    else $error("Oscillation reported without a swing above threshold.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_stall_kind == STALL_NONE)) |->
      ((out_stall_iteration == '0) && (out_largest_swing == '0) &&
       (out_window_change == '0) && (out_reads_involved == '0)))
    else $error("A result without a stall carries non-zero fields.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !wr_en)
    else $error("History written while the window walk is reading it.");

endmodule
